>>> hdl/whp_pkg.sv
// shared types and constants for the wav header parser
package whp_pkg;

  // parse phases
  typedef enum logic [3:0] {
    PH_RIFF  = 4'd0,
    PH_RSIZE = 4'd1,
    PH_WAVE  = 4'd2,
    PH_FMTS  = 4'd3,
    PH_FSIZE = 4'd4,
    PH_FBODY = 4'd5,
    PH_SKIP  = 4'd6,
    PH_DSCAN = 4'd7,
    PH_DLEN  = 4'd8,
    PH_DONE  = 4'd9
  } phase_t;

  // result status codes
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_NO_RIFF   = 3'd1;
  localparam logic [2:0] ST_NOT_WAVE  = 3'd2;
  localparam logic [2:0] ST_FMT_BIG   = 3'd3;
  localparam logic [2:0] ST_NOT_PCM   = 3'd4;
  localparam logic [2:0] ST_BAD_CHAN  = 3'd5;
  localparam logic [2:0] ST_BAD_WIDTH = 3'd6;
  localparam logic [2:0] ST_TRUNC     = 3'd7;

  // chunk tags, first byte in the top position
  localparam logic [31:0] TAG_RIFF = 32'h5249_4646;
  localparam logic [31:0] TAG_WAVE = 32'h5741_5645;
  localparam logic [23:0] TAG_FMT  = 24'h66_6D74;
  localparam logic [31:0] TAG_DATA = 32'h6461_7461;

  localparam logic [15:0] FMT_MAX  = 16'd40;
  localparam logic [7:0]  FMT_BASE = 8'd16;
  localparam logic [31:0] LEN_BIAS = 32'd44;
  localparam logic [15:0] FMT_PCM  = 16'd1;

  // one result item
  typedef struct packed {
    logic [2:0]  status;
    logic [1:0]  channels;
    logic [4:0]  sample_bits;
    logic [31:0] rate_hz;
    logic [31:0] bits_per_second;
    logic [31:0] data_offset;
    logic [31:0] data_length;
  } whp_result_t;

endpackage

>>> hdl/whp_parser.sv
// byte-wise parse state and result decode for the wav header parser
module whp_parser (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 take,
  input  logic [7:0]           data_byte,
  input  logic                 first_byte,
  input  logic                 last_byte,
  output logic                 hit,
  output whp_pkg::whp_result_t result
);
  import whp_pkg::*;

  phase_t      phase, phase_next, cur_phase;
  logic [4:0]  field_count, field_count_next, cur_fc;
  logic [31:0] position, position_next, cur_pos;
  logic [31:0] window, window_next, cur_win;
  logic [15:0] fmt_size, fmt_size_next, cur_fmt;
  logic [15:0] format_code, format_code_next, cur_format;
  logic [15:0] channel_count, channel_count_next, cur_chan;
  logic [31:0] rate_store, rate_store_next, cur_rate;
  logic [15:0] width_store, width_store_next, cur_width;
  logic [7:0]  skip_left, skip_left_next, cur_skip;
  logic [31:0] len_swap;
  logic [31:0] bps;
  logic        ok_hit;
  logic        err_hit;
  logic [2:0]  err_code;

  // a first byte starts from the cleared state
  always_comb begin
    cur_phase  = first_byte ? PH_RIFF : phase;
    cur_fc     = first_byte ? 5'd0  : field_count;
    cur_pos    = first_byte ? 32'd0 : position;
    cur_win    = first_byte ? 32'd0 : window;
    cur_fmt    = first_byte ? 16'd0 : fmt_size;
    cur_format = first_byte ? 16'd0 : format_code;
    cur_chan   = first_byte ? 16'd0 : channel_count;
    cur_rate   = first_byte ? 32'd0 : rate_store;
    cur_width  = first_byte ? 16'd0 : width_store;
    cur_skip   = first_byte ? 8'd0  : skip_left;
  end

  // next state and result decision
  always_comb begin
    phase_next         = cur_phase;
    field_count_next   = cur_fc;
    position_next      = cur_pos;
    window_next        = cur_win;
    fmt_size_next      = cur_fmt;
    format_code_next   = cur_format;
    channel_count_next = cur_chan;
    rate_store_next    = cur_rate;
    width_store_next   = cur_width;
    skip_left_next     = cur_skip;
    ok_hit             = 1'b0;
    err_hit            = 1'b0;
    err_code           = ST_TRUNC;

    if (cur_phase != PH_DONE) begin
      position_next    = cur_pos + 32'd1;
      window_next      = {cur_win[23:0], data_byte};
      field_count_next = cur_fc + 5'd1;

      unique case (cur_phase)
        PH_RIFF: begin
          if (field_count_next == 5'd4) begin
            field_count_next = 5'd0;
            if (window_next != TAG_RIFF) begin
              err_hit  = 1'b1;
              err_code = ST_NO_RIFF;
            end else begin
              phase_next = PH_RSIZE;
            end
          end
        end
        PH_RSIZE: begin
          if (field_count_next == 5'd4) begin
            field_count_next = 5'd0;
            phase_next       = PH_WAVE;
          end
        end
        PH_WAVE: begin
          if (field_count_next == 5'd4) begin
            field_count_next = 5'd0;
            if (window_next != TAG_WAVE) begin
              err_hit  = 1'b1;
              err_code = ST_NOT_WAVE;
            end else begin
              phase_next = PH_FMTS;
            end
          end
        end
        PH_FMTS: begin
          if (field_count_next == 5'd4) begin
            field_count_next = 5'd0;
            if (window_next[31:8] == TAG_FMT) begin
              phase_next    = PH_FSIZE;
              fmt_size_next = 16'd0;
            end
          end
        end
        PH_FSIZE: begin
          if (field_count_next == 5'd1) begin
            fmt_size_next = {8'd0, data_byte};
          end else if (field_count_next == 5'd2) begin
            fmt_size_next = {data_byte, cur_fmt[7:0]};
          end else if (field_count_next == 5'd4) begin
            field_count_next = 5'd0;
            if (cur_fmt > FMT_MAX) begin
              err_hit  = 1'b1;
              err_code = ST_FMT_BIG;
            end else begin
              skip_left_next = cur_fmt[7:0] - FMT_BASE;
              phase_next     = PH_FBODY;
            end
          end
        end
        PH_FBODY: begin
          // old count is the byte index within the 16 format bytes
          unique case (cur_fc)
            5'd0:    format_code_next[7:0]    = data_byte;
            5'd1:    format_code_next[15:8]   = data_byte;
            5'd2:    channel_count_next[7:0]  = data_byte;
            5'd3:    channel_count_next[15:8] = data_byte;
            5'd4:    rate_store_next[7:0]     = data_byte;
            5'd5:    rate_store_next[15:8]    = data_byte;
            5'd6:    rate_store_next[23:16]   = data_byte;
            5'd7:    rate_store_next[31:24]   = data_byte;
            5'd14:   width_store_next[7:0]    = data_byte;
            5'd15:   width_store_next[15:8]   = data_byte;
            default: ;
          endcase
          if (field_count_next == 5'd16) begin
            field_count_next = 5'd0;
            window_next      = 32'd0;
            if (format_code_next != FMT_PCM) begin
              err_hit  = 1'b1;
              err_code = ST_NOT_PCM;
            end else if (channel_count_next != 16'd1 && channel_count_next != 16'd2) begin
              err_hit  = 1'b1;
              err_code = ST_BAD_CHAN;
            end else if (width_store_next != 16'd8 && width_store_next != 16'd16) begin
              err_hit  = 1'b1;
              err_code = ST_BAD_WIDTH;
            end else begin
              phase_next = (cur_skip == 8'd0) ? PH_DSCAN : PH_SKIP;
            end
          end
        end
        PH_SKIP: begin
          field_count_next = 5'd0;
          skip_left_next   = cur_skip - 8'd1;
          if (skip_left_next == 8'd0) begin
            phase_next  = PH_DSCAN;
            window_next = 32'd0;
          end
        end
        PH_DSCAN: begin
          if (field_count_next > 5'd4) field_count_next = 5'd4;
          if (field_count_next == 5'd4 && window_next == TAG_DATA) begin
            field_count_next = 5'd0;
            window_next      = 32'd0;
            phase_next       = PH_DLEN;
          end
        end
        PH_DLEN: begin
          if (field_count_next == 5'd4) ok_hit = 1'b1;
        end
        default: phase_next = PH_DONE;
      endcase

      // an early end gives a truncated status
      if (!ok_hit && !err_hit && last_byte) begin
        err_hit  = 1'b1;
        err_code = ST_TRUNC;
      end
      if (ok_hit || err_hit) phase_next = PH_DONE;
    end
  end

  // length bytes arrive little endian, first in the top of the window
  assign len_swap = {window_next[7:0], window_next[15:8],
                     window_next[23:16], window_next[31:24]};

  // channels and width are 1/2 and 8/16 here, so the product is shifts
  always_comb begin
    bps = (cur_width[4]) ? {cur_rate[27:0], 4'd0} : {cur_rate[28:0], 3'd0};
    if (cur_chan[1]) bps = {bps[30:0], 1'b0};
  end

  // result fields
  always_comb begin
    hit    = ok_hit || err_hit;
    result = '0;
    if (ok_hit) begin
      result.status          = ST_OK;
      result.channels        = cur_chan[1:0];
      result.sample_bits     = cur_width[4:0];
      result.rate_hz         = cur_rate;
      result.bits_per_second = bps;
      result.data_offset     = position_next;
      result.data_length     = len_swap - LEN_BIAS;
    end else if (err_hit) begin
      result.status = err_code;
    end
  end

  // parse state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_RIFF;
      field_count   <= 5'd0;
      position      <= 32'd0;
      window        <= 32'd0;
      fmt_size      <= 16'd0;
      format_code   <= 16'd0;
      channel_count <= 16'd0;
      rate_store    <= 32'd0;
      width_store   <= 16'd0;
      skip_left     <= 8'd0;
    end else if (take) begin
      phase         <= phase_next;
      field_count   <= field_count_next;
      position      <= position_next;
      window        <= window_next;
      fmt_size      <= fmt_size_next;
      format_code   <= format_code_next;
      channel_count <= channel_count_next;
      rate_store    <= rate_store_next;
      width_store   <= width_store_next;
      skip_left     <= skip_left_next;
    end
  end

endmodule

>>> hdl/wav_header_parser_core.sv
// top level of the wav header parser: byte input, parser and result register
//
// channel | direction | handshake              | payload
// in      | input     | in_valid / in_stall    | data_byte, first_byte, last_byte
// out     | output    | out_valid / out_stall  | status .. data_length
//
// one byte is taken per cycle while in_stall is low; each byte updates the parse state in that cycle
// a result is registered and appears on out in the cycle after the byte that completes it
// rst is synchronous and returns the parser to the riff tag check
// a waiting result stalls only a byte that would produce another result
module wav_header_parser_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  data_byte,
  input  logic        first_byte,
  input  logic        last_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  status,
  output logic [1:0]  channels,
  output logic [4:0]  sample_bits,
  output logic [31:0] rate_hz,
  output logic [31:0] bits_per_second,
  output logic [31:0] data_offset,
  output logic [31:0] data_length
);
  import whp_pkg::*;

  logic        take;
  logic        hit;
  whp_result_t result;
  whp_result_t res_reg;

  // hold off only when a new result would overwrite an unread one
  assign in_stall = out_valid && out_stall && hit;
  assign take     = in_valid && !in_stall;

  whp_parser u_parser (
    .clk        (clk),
    .rst        (rst),
    .take       (take),
    .data_byte  (data_byte),
    .first_byte (first_byte),
    .last_byte  (last_byte),
    .hit        (hit),
    .result     (result)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take && hit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take && hit) res_reg <= result;
  end

  assign status          = res_reg.status;
  assign channels        = res_reg.channels;
  assign sample_bits     = res_reg.sample_bits;
  assign rate_hz         = res_reg.rate_hz;
  assign bits_per_second = res_reg.bits_per_second;
  assign data_offset     = res_reg.data_offset;
  assign data_length     = res_reg.data_length;

endmodule

>>> bench/wav_header_parser_core_test.sv
// self-checking bench for the wav header parser: file streams in, parsed headers out
module wav_header_parser_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  import whp_pkg::*;

  localparam int IDLE_LIMIT = 4000;
  localparam int RANDOM_BYTES = 430;
  localparam int RANDOM_FILES = 4;
  localparam logic [31:0] FMT_GROUP = {TAG_FMT, 8'h20};

  // one byte request as offered to the block
  typedef struct packed {
    logic [7:0] b;
    logic       first;
    logic       last;
    logic       typed;
    logic [2:0] st;
  } byte_req_t;

  // recipe for one file; junk_word of zero means random junk groups
  typedef struct packed {
    logic [31:0] riff;
    logic [31:0] wave;
    logic [31:0] junk_n;
    logic [31:0] junk_word;
    logic [31:0] fsz;
    logic [31:0] code;
    logic [31:0] chans;
    logic [31:0] rate;
    logic [31:0] bits;
    bit          skip_pat;
    logic [31:0] pre_n;
    logic [31:0] dlen;
    logic [31:0] tail_n;
    logic [31:0] cut;
    bit          start;
    bit          end_mark;
    bit          typed;
    logic [2:0]  st;
  } file_t;

  typedef enum logic [1:0] {RX_FREE, RX_LIGHT, RX_HEAVY, RX_TOGGLE} rx_mode_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  data_byte = '0;
  logic        first_byte = 1'b0;
  logic        last_byte = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [2:0]  status;
  logic [1:0]  channels;
  logic [4:0]  sample_bits;
  logic [31:0] rate_hz;
  logic [31:0] bits_per_second;
  logic [31:0] data_offset;
  logic [31:0] data_length;

  // bench-side tags that travel with the driven byte
  logic        drv_typed = 1'b0;
  logic [2:0]  drv_st = ST_OK;

  byte_req_t   req_q[$];
  logic [7:0]  file_bytes[$];
  whp_result_t header_q[$];

  int errors = 0;
  int n_bytes = 0;
  int n_files = 0;
  int n_headers = 0;
  int status_count[8];

  // predictor state
  phase_t      ph;
  logic [4:0]  fcnt;
  logic [31:0] pos;
  logic [31:0] win;
  logic [15:0] fsize;
  logic [15:0] fcode;
  logic [15:0] nchan;
  logic [31:0] rate;
  logic [15:0] width;
  logic [7:0]  skip;

  // directed files: riff, wave, junk_n, junk_word, fsz, code, chans, rate, bits,
  // skip_pat, pre_n, dlen, tail_n, cut, start, end_mark, typed, st
  file_t plan [0:21] = '{
    // first file straight after reset, no restart flag
    '{TAG_RIFF, TAG_WAVE, 0, 0, 16, 1, 1, 8000, 8, 1'b0, 0, 1000, 0, 0,
      1'b0, 1'b1, 1'b0, ST_OK},
    // largest fmt size, top rate and length, last flag on an ignored tail byte
    '{TAG_RIFF, TAG_WAVE, 0, 0, 40, 1, 2, 32'hFFFF_FFFF, 16, 1'b0, 0, 32'hFFFF_FFFF, 3, 0,
      1'b1, 1'b1, 1'b0, ST_OK},
    // upper size bytes ignored, zero rate, zero length wraps
    '{TAG_RIFF, TAG_WAVE, 0, 0, 32'hFFFF_0012, 1, 1, 0, 16, 1'b0, 0, 0, 0, 0,
      1'b1, 1'b1, 1'b0, ST_OK},
    // size zero skips 240 bytes
    '{TAG_RIFF, TAG_WAVE, 0, 0, 0, 1, 2, 44100, 8, 1'b0, 2, 44, 0, 0,
      1'b1, 1'b1, 1'b0, ST_OK},
    // size 15 skips 255 bytes full of data tags; the scan starts clean
    '{TAG_RIFF, TAG_WAVE, 0, 0, 15, 1, 1, 48000, 16, 1'b1, 1, 43, 0, 0,
      1'b1, 1'b1, 1'b0, ST_OK},
    // misaligned fmt in the groups before the real one
    '{TAG_RIFF, TAG_WAVE, 3, 32'h2066_6D74, 18, 1, 2, 22050, 16, 1'b1, 5, 32'h1234_5678, 0, 0,
      1'b1, 1'b1, 1'b0, ST_OK},
    // no last flag at all, trailing bytes ignored
    '{TAG_RIFF, TAG_WAVE, 2, 0, 20, 1, 2, 11025, 8, 1'b0, 3, 32'h0000_1000, 4, 0,
      1'b1, 1'b0, 1'b0, ST_OK},
    '{32'h5249_4647, TAG_WAVE, 0, 0, 16, 1, 1, 8000, 8, 1'b0, 0, 100, 0, 0,
      1'b1, 1'b1, 1'b1, ST_NO_RIFF},
    '{32'h0000_0000, TAG_WAVE, 0, 0, 16, 1, 1, 8000, 8, 1'b0, 0, 100, 0, 0,
      1'b1, 1'b1, 1'b1, ST_NO_RIFF},
    '{TAG_RIFF, 32'h5741_5644, 0, 0, 16, 1, 1, 8000, 8, 1'b0, 0, 100, 0, 0,
      1'b1, 1'b1, 1'b1, ST_NOT_WAVE},
    '{TAG_RIFF, TAG_WAVE, 0, 0, 41, 1, 1, 8000, 8, 1'b0, 0, 100, 0, 0,
      1'b1, 1'b1, 1'b1, ST_FMT_BIG},
    '{TAG_RIFF, TAG_WAVE, 1, 0, 32'h0000_FFFF, 1, 1, 8000, 8, 1'b0, 0, 100, 0, 0,
      1'b1, 1'b1, 1'b1, ST_FMT_BIG},
    '{TAG_RIFF, TAG_WAVE, 0, 0, 16, 0, 1, 8000, 8, 1'b0, 0, 100, 0, 0,
      1'b1, 1'b1, 1'b1, ST_NOT_PCM},
    '{TAG_RIFF, TAG_WAVE, 0, 0, 16, 32'hFFFF, 1, 8000, 8, 1'b0, 0, 100, 0, 0,
      1'b1, 1'b1, 1'b1, ST_NOT_PCM},
    '{TAG_RIFF, TAG_WAVE, 0, 0, 16, 1, 0, 8000, 8, 1'b0, 0, 100, 0, 0,
      1'b1, 1'b1, 1'b1, ST_BAD_CHAN},
    '{TAG_RIFF, TAG_WAVE, 0, 0, 16, 1, 3, 8000, 8, 1'b0, 0, 100, 0, 0,
      1'b1, 1'b1, 1'b1, ST_BAD_CHAN},
    '{TAG_RIFF, TAG_WAVE, 0, 0, 16, 1, 32'h0101, 8000, 8, 1'b0, 0, 100, 0, 0,
      1'b1, 1'b1, 1'b1, ST_BAD_CHAN},
    '{TAG_RIFF, TAG_WAVE, 0, 0, 16, 1, 2, 8000, 0, 1'b0, 0, 100, 0, 0,
      1'b1, 1'b1, 1'b1, ST_BAD_WIDTH},
    '{TAG_RIFF, TAG_WAVE, 0, 0, 16, 1, 2, 8000, 32'hFFFF, 1'b0, 0, 100, 0, 0,
      1'b1, 1'b1, 1'b1, ST_BAD_WIDTH},
    // one-byte file carrying both flags
    '{TAG_RIFF, TAG_WAVE, 0, 0, 16, 1, 1, 8000, 8, 1'b0, 0, 100, 0, 1,
      1'b1, 1'b1, 1'b1, ST_TRUNC},
    // cut inside the format body without a last flag, next file restarts
    '{TAG_RIFF, TAG_WAVE, 0, 0, 16, 1, 1, 8000, 8, 1'b0, 0, 100, 0, 30,
      1'b1, 1'b0, 1'b0, ST_OK},
    // stream ends on the data tag itself
    '{TAG_RIFF, TAG_WAVE, 0, 0, 16, 1, 1, 8000, 8, 1'b0, 0, 100, 0, 40,
      1'b1, 1'b1, 1'b1, ST_TRUNC}
  };

  wav_header_parser_core u_dut (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .data_byte       (data_byte),
    .first_byte      (first_byte),
    .last_byte       (last_byte),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .status          (status),
    .channels        (channels),
    .sample_bits     (sample_bits),
    .rate_hz         (rate_hz),
    .bits_per_second (bits_per_second),
    .data_offset     (data_offset),
    .data_length     (data_length)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // parser state back to the riff tag check
  function automatic void clear_state();
    ph = PH_RIFF;
    fcnt = '0;
    pos = '0;
    win = '0;
    fsize = '0;
    fcode = '0;
    nchan = '0;
    rate = '0;
    width = '0;
    skip = '0;
  endfunction

  // advance the parser by one byte; returns 1 when a header or error comes out
  function automatic bit parse_byte(input logic [7:0] b, input logic first,
                                    input logic last, output whp_result_t hdr);
    bit hit;
    logic [4:0] i;
    logic [31:0] len;
    hdr = '0;
    hit = 1'b0;
    if (first) clear_state();
    if (ph == PH_DONE) return 1'b0;
    pos = pos + 32'd1;
    win = {win[23:0], b};
    fcnt = fcnt + 5'd1;
    case (ph)
      PH_RIFF: begin
        if (fcnt == 5'd4) begin
          fcnt = '0;
          if (win != TAG_RIFF) begin
            hdr.status = ST_NO_RIFF;
            hit = 1'b1;
          end else ph = PH_RSIZE;
        end
      end
      PH_RSIZE: begin
        if (fcnt == 5'd4) begin
          fcnt = '0;
          ph = PH_WAVE;
        end
      end
      PH_WAVE: begin
        if (fcnt == 5'd4) begin
          fcnt = '0;
          if (win != TAG_WAVE) begin
            hdr.status = ST_NOT_WAVE;
            hit = 1'b1;
          end else ph = PH_FMTS;
        end
      end
      PH_FMTS: begin
        if (fcnt == 5'd4) begin
          fcnt = '0;
          if (win[31:8] == TAG_FMT) begin
            ph = PH_FSIZE;
            fsize = '0;
          end
        end
      end
      PH_FSIZE: begin
        if (fcnt == 5'd1) fsize = {8'h00, b};
        else if (fcnt == 5'd2) fsize[15:8] = b;
        else if (fcnt == 5'd4) begin
          fcnt = '0;
          if (fsize > FMT_MAX) begin
            hdr.status = ST_FMT_BIG;
            hit = 1'b1;
          end else begin
            skip = fsize[7:0] - FMT_BASE;
            ph = PH_FBODY;
          end
        end
      end
      PH_FBODY: begin
        // little-endian fields: format, channels, rate, then bits at the end
        i = fcnt - 5'd1;
        if (i < 2) fcode = fcode | ({8'h00, b} << (8 * i));
        else if (i < 4) nchan = nchan | ({8'h00, b} << (8 * (i - 2)));
        else if (i < 8) rate = rate | ({24'h0, b} << (8 * (i - 4)));
        else if (i >= 14 && i < 16) width = width | ({8'h00, b} << (8 * (i - 14)));
        if (fcnt == 5'd16) begin
          fcnt = '0;
          win = '0;
          if (fcode != FMT_PCM) begin
            hdr.status = ST_NOT_PCM;
            hit = 1'b1;
          end else if (nchan != 16'd1 && nchan != 16'd2) begin
            hdr.status = ST_BAD_CHAN;
            hit = 1'b1;
          end else if (width != 16'd8 && width != 16'd16) begin
            hdr.status = ST_BAD_WIDTH;
            hit = 1'b1;
          end else ph = (skip == 8'd0) ? PH_DSCAN : PH_SKIP;
        end
      end
      PH_SKIP: begin
        fcnt = '0;
        skip = skip - 8'd1;
        if (skip == 8'd0) begin
          ph = PH_DSCAN;
          win = '0;
        end
      end
      PH_DSCAN: begin
        if (fcnt > 5'd4) fcnt = 5'd4;
        if (fcnt == 5'd4 && win == TAG_DATA) begin
          fcnt = '0;
          win = '0;
          ph = PH_DLEN;
        end
      end
      PH_DLEN: begin
        if (fcnt == 5'd4) begin
          len = {win[7:0], win[15:8], win[23:16], win[31:24]};
          hdr.status = ST_OK;
          hdr.channels = nchan[1:0];
          hdr.sample_bits = width[4:0];
          hdr.rate_hz = rate;
          hdr.bits_per_second = {16'h0, nchan} * rate * {16'h0, width};
          hdr.data_offset = pos;
          hdr.data_length = len - LEN_BIAS;
          hit = 1'b1;
        end
      end
      default: ph = PH_DONE;
    endcase
    if (hit) ph = PH_DONE;
    else if (last) begin
      hdr.status = ST_TRUNC;
      hit = 1'b1;
      ph = PH_DONE;
    end
    return hit;
  endfunction

  function automatic void put_word(logic [31:0] w, int nb, bit big);
    for (int k = 0; k < nb; k++)
      file_bytes = {file_bytes, (big ? w[8 * (nb - 1 - k) +: 8] : w[8 * k +: 8])};
  endfunction

  // lay out one file and queue its bytes; returns the number queued
  function automatic int add_file(file_t f);
    int n;
    int nskip;
    byte_req_t r;
    logic [7:0] low;
    file_bytes.delete();
    put_word(f.riff, 4, 1'b1);
    put_word($urandom(), 4, 1'b0);
    put_word(f.wave, 4, 1'b1);
    for (int k = 0; k < f.junk_n; k++)
      put_word((f.junk_word != 0) ? f.junk_word : $urandom(), 4, 1'b1);
    put_word(FMT_GROUP, 4, 1'b1);
    put_word(f.fsz, 4, 1'b0);
    put_word(f.code, 2, 1'b0);
    put_word(f.chans, 2, 1'b0);
    put_word(f.rate, 4, 1'b0);
    put_word($urandom(), 4, 1'b0);
    put_word($urandom(), 2, 1'b0);
    put_word(f.bits, 2, 1'b0);
    low = f.fsz[7:0] - FMT_BASE;
    nskip = int'(low);
    // skip and filler bytes either random or a running data tag pattern
    for (int k = 0; k < nskip + f.pre_n; k++)
      file_bytes = {file_bytes,
                    (f.skip_pat ? TAG_DATA[8 * (3 - k % 4) +: 8] : 8'($urandom()))};
    put_word(TAG_DATA, 4, 1'b1);
    put_word(f.dlen, 4, 1'b0);
    for (int k = 0; k < f.tail_n; k++) file_bytes = {file_bytes, 8'($urandom())};
    n = file_bytes.size();
    if (f.cut != 0 && f.cut < n) n = int'(f.cut);
    for (int k = 0; k < n; k++) begin
      r.b = file_bytes[k];
      r.first = (k == 0) && f.start;
      r.last = (k == n - 1) && f.end_mark;
      r.typed = f.typed;
      r.st = f.st;
      req_q = {req_q, r};
    end
    n_files++;
    return n;
  endfunction

  // mostly well-formed files with random content, some broken or cut short
  function automatic file_t random_file(int kind);
    file_t f;
    logic [2:0] err;
    f.riff = TAG_RIFF;
    f.wave = TAG_WAVE;
    f.junk_n = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
    f.junk_word = 0;
    f.fsz = {16'($urandom()),
             16'(($urandom_range(0, 19) == 0) ? $urandom_range(0, 15) : $urandom_range(16, 40))};
    f.code = {16'h0, FMT_PCM};
    f.chans = $urandom_range(1, 2);
    f.rate = $urandom();
    f.bits = $urandom_range(0, 1) ? 16 : 8;
    f.skip_pat = 1'($urandom_range(0, 1));
    f.pre_n = $urandom_range(0, 6);
    f.dlen = $urandom();
    f.tail_n = $urandom_range(0, 3);
    f.cut = 0;
    f.start = 1'b1;
    f.end_mark = ($urandom_range(0, 4) != 0);
    f.typed = 1'b0;
    f.st = ST_OK;
    if (kind >= 70 && kind < 85) begin
      err = 3'($urandom_range(1, 6));
      case (err)
        ST_NO_RIFF:  f.riff = f.riff ^ (32'd1 << $urandom_range(0, 31));
        ST_NOT_WAVE: f.wave = f.wave ^ (32'd1 << $urandom_range(0, 31));
        ST_FMT_BIG:  f.fsz[15:0] = 16'($urandom_range(41, 65535));
        ST_NOT_PCM: begin
          f.code = {16'h0, 16'($urandom())};
          if (f.code == FMT_PCM) f.code = 0;
        end
        ST_BAD_CHAN: begin
          f.chans = {16'h0, 16'($urandom())};
          if (f.chans == 1 || f.chans == 2) f.chans = 3;
        end
        default: begin
          f.bits = {16'h0, 16'($urandom())};
          if (f.bits == 8 || f.bits == 16) f.bits = 24;
        end
      endcase
    end else if (kind >= 85) begin
      f.cut = $urandom_range(1, 80);
    end
    return f;
  endfunction

  int burst_left = 1;
  int gap_left = 0;

  // byte sender: bursts of random length separated by random gaps
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) req_q.delete(0);
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (req_q.size() > 0) begin
          in_valid <= 1'b1;
          data_byte <= req_q[0].b;
          first_byte <= req_q[0].first;
          last_byte <= req_q[0].last;
          drv_typed <= req_q[0].typed;
          drv_st <= req_q[0].st;
          if (burst_left <= 1) begin
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 400)
                                                      : $urandom_range(1, 24);
            gap_left = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60)
                                                    : $urandom_range(0, 4);
          end else burst_left--;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // header receiver: stall pattern picked at random from four modes, plus long hold-offs
  int rx_cyc = 0;
  int hold_left = 0;
  rx_mode_t rx_mode = RX_FREE;

  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      rx_cyc++;
      if (rx_cyc % 2048 == 1024) hold_left = 600;
      if (rx_cyc % 128 == 0) rx_mode = rx_mode_t'($urandom_range(0, 3));
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        case (rx_mode)
          RX_FREE:  out_stall <= 1'b0;
          RX_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
          RX_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
          default:  out_stall <= ~out_stall;
        endcase
      end
    end
  end

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      errors++;
    end
  endtask

  // predict on each accepted byte, compare on each accepted header
  always @(posedge clk) begin
    whp_result_t want;
    whp_result_t got;
    bit hit;
    if (rst) begin
      clear_state();
      header_q.delete();
    end else begin
      if (in_valid && !in_stall) begin
        hit = parse_byte(data_byte, first_byte, last_byte, want);
        if (hit) begin
          if (drv_typed) begin
            want = '0;
            want.status = drv_st;
          end
          header_q = {header_q, want};
          n_headers++;
          status_count[want.status]++;
        end
      end
      if (out_valid && !out_stall) begin
        got = '{status, channels, sample_bits, rate_hz, bits_per_second,
                data_offset, data_length};
        if (header_q.size() == 0) begin
          $display("%0t ns: unexpected header, expected none, actual status %0d",
                   $time, got.status);
          errors++;
        end else begin
          want = header_q.pop_front();
          check_field("status", 32'(want.status), 32'(got.status));
          check_field("channels", 32'(want.channels), 32'(got.channels));
          check_field("sample_bits", 32'(want.sample_bits), 32'(got.sample_bits));
          check_field("rate_hz", want.rate_hz, got.rate_hz);
          check_field("bits_per_second", want.bits_per_second, got.bits_per_second);
          check_field("data_offset", want.data_offset, got.data_offset);
          check_field("data_length", want.data_length, got.data_length);
        end
      end
    end
  end

  // watchdog on cycles with no transfer on either side
  int idle_cycles = 0;

  always @(posedge clk) begin
    if (!rst) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles == IDLE_LIMIT) begin
        $display("%0t ns: no transfer for %0d cycles", $time, IDLE_LIMIT);
        $display("status: fail");
        $finish;
      end
    end
  end

  initial begin
    int kind;
    int rand_bytes;
    int rand_files;
    byte_req_t r;
    rand_bytes = 0;
    rand_files = 0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // directed files
    foreach (plan[k]) n_bytes += add_file(plan[k]);
    while (req_q.size() > 0 || in_valid) @(posedge clk);

    // random files and noise, fed as the queue drains
    while (rand_bytes < RANDOM_BYTES || rand_files < RANDOM_FILES) begin
      if (req_q.size() > 64) begin
        @(posedge clk);
      end else begin
        kind = $urandom_range(0, 99);
        if (kind >= 95) begin
          for (int k = $urandom_range(1, 40); k > 0; k--) begin
            r.b = 8'($urandom());
            r.first = ($urandom_range(0, 7) == 0);
            r.last = ($urandom_range(0, 7) == 0);
            r.typed = 1'b0;
            r.st = ST_OK;
            req_q = {req_q, r};
            rand_bytes++;
          end
          n_files++;
        end else begin
          rand_bytes += add_file(random_file(kind));
        end
        rand_files++;
      end
    end
    n_bytes += rand_bytes;

    while (req_q.size() > 0 || in_valid || header_q.size() > 0) @(posedge clk);
    repeat (8) @(posedge clk);
    @(negedge clk);
    if (header_q.size() != 0) begin
      $display("%0t ns: %0d expected headers never arrived", $time, header_q.size());
      errors += header_q.size();
    end
    $display("covered %0d files and noise runs, %0d bytes queued, %0d results",
             n_files, n_bytes, n_headers);
    $display("results: %0d ok, %0d truncated, %0d rejected, %0d mismatches",
             status_count[ST_OK], status_count[ST_TRUNC],
             n_headers - status_count[ST_OK] - status_count[ST_TRUNC], errors);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
